// ----- src/pnu_pkg.sv -----
package pnu_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_MAX_SPEED = 3'd0;
    localparam logic [2:0] REG_DAMPING   = 3'd1;
    localparam logic [2:0] REG_MIN_X     = 3'd2;
    localparam logic [2:0] REG_MAX_X     = 3'd3;
    localparam logic [2:0] REG_MIN_Y     = 3'd4;
    localparam logic [2:0] REG_MAX_Y     = 3'd5;
    localparam logic [2:0] REG_MIN_Z     = 3'd6;
    localparam logic [2:0] REG_MAX_Z     = 3'd7;

    localparam logic [30:0] MAX_SPEED_RST = 31'd655360;
    localparam logic [16:0] DAMPING_RST   = 17'd6554;
    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [31:0] Q16_MIN       = 32'h8000_0000;
    localparam logic [31:0] Q16_MAX       = 32'h7FFF_FFFF;

    // Root steps and quotient bits, one per pipeline stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0]       lk;
    } node_t;

    typedef struct packed {
        node_t            nd;
        logic [2:0]       neg;
        logic [2:0][62:0] num;
        logic             over;
        logic [63:0]      n;
        logic [63:0]      res;
    } sqrt_t;

    typedef struct packed {
        node_t            nd;
        logic [2:0]       neg;
        logic             over;
        logic [31:0]      dvs;
        logic [2:0][32:0] rem;
        logic [2:0][31:0] low;
        logic [2:0][31:0] quo;
    } div_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return Q16_MAX;
        end else if (v < -34'sd2147483648) begin
            return Q16_MIN;
        end
        return v[31:0];
    endfunction

    // One step of the digit-by-digit integer square root
    function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] bitv);
        sqrt_t       o;
        logic [63:0] t;
        o = s;
        t = s.res + bitv;
        if (s.n >= t) begin
            o.n   = s.n - t;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // One restoring division step on all three lanes
    function automatic div_t div_step(input div_t s);
        div_t        o;
        logic [32:0] r2;
        o = s;
        for (int i = 0; i < 3; i++) begin
            r2 = {s.rem[i][31:0], s.low[i][31]};
            if (r2 >= {1'b0, s.dvs}) begin
                o.rem[i] = r2 - {1'b0, s.dvs};
                o.quo[i] = {s.quo[i][30:0], 1'b1};
            end else begin
                o.rem[i] = r2;
                o.quo[i] = {s.quo[i][30:0], 1'b0};
            end
            o.low[i] = {s.low[i][30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ----- src/particle_node_update.sv -----
// Particle node update: one damped integration step with speed limit and bounce.
// Input channel (s_*): one node per transaction, position, velocity, gravity and
// lock flags. Result channel (m_*): the node's new position and velocity.
// Configuration: write cfg_data to register cfg_index while cfg_wr_en is high;
// 0 max_speed, 1 damping, 2..7 min/max bounds of x, y and z. Write only while
// no transaction is in flight.
// Throughput: one node per cycle while the receiver does not stall. The path from
// input to output register runs through the 32-stage square root of the squared speed and the
// 32-stage divider that rescales each velocity component, one bit per stage.
// All stages move together; the pipeline advances whenever the output register
// is empty or being taken, so a stall of the receiver holds every stage in
// place and s_ready drops with it. Nothing is lost or repeated.
// Reset clears all valid bits and loads the configuration defaults (max_speed
// 10.0, damping 0.1, bounds at the full 32-bit range).
module particle_node_update (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_vel_z,
    input  logic signed [31:0] s_gravity,
    input  logic               s_node_locked,
    input  logic               s_lock_x,
    input  logic               s_lock_y,
    input  logic               s_lock_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_pos_z,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic signed [31:0] m_new_vel_z,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [30:0]       max_speed_reg;
    logic [16:0]       damping_reg;
    logic [2:0][31:0]  min_reg;
    logic [2:0][31:0]  max_reg;
    logic [16:0]       factor;
    logic              adv;

    pnu_pkg::node_t    a_reg, a_next;
    logic              a_vld_reg;
    pnu_pkg::node_t    b_reg;
    logic [2:0][31:0]  b_mag_reg;
    logic [2:0]        b_neg_reg;
    logic              b_vld_reg;
    pnu_pkg::node_t    c_reg;
    logic [2:0]        c_neg_reg;
    logic [2:0][63:0]  c_sq_reg;
    logic [2:0][62:0]  c_num_reg;
    logic [61:0]       c_lim2_reg;
    logic              c_vld_reg;
    pnu_pkg::node_t    d_reg;
    logic [2:0]        d_neg_reg;
    logic [2:0][62:0]  d_num_reg;
    logic [61:0]       d_lim2_reg;
    logic [63:0]       d_mag2_reg;
    logic              d_vld_reg;

    pnu_pkg::sqrt_t    sq_reg [pnu_pkg::SQRT_STEPS+1];
    logic              sq_vld_reg [pnu_pkg::SQRT_STEPS+1];
    pnu_pkg::div_t     dv_in;
    pnu_pkg::div_t     dv_reg [pnu_pkg::DIV_STEPS];
    logic              dv_vld_reg [pnu_pkg::DIV_STEPS];

    pnu_pkg::node_t    f_reg, f_next;
    logic              f_vld_reg;
    pnu_pkg::node_t    g_reg, g_next;
    logic              g_vld_reg;
    pnu_pkg::node_t    h_reg, h_next;
    logic              h_vld_reg;
    pnu_pkg::node_t    i_reg, i_next;
    logic              i_vld_reg;
    logic [2:0][31:0]  j_pos_reg;
    logic [2:0][31:0]  j_mag_reg;
    logic [2:0]        j_neg_reg;
    logic              j_vld_reg;
    logic [2:0][31:0]  k_pos_reg;
    logic [2:0][48:0]  k_prod_reg;
    logic [2:0]        k_neg_reg;
    logic              k_vld_reg;
    logic [2:0][31:0]  out_pos_reg;
    logic [2:0][31:0]  out_vel_reg, out_vel_next;
    logic              out_vld_reg;
    logic [32:0]       gsum;

    // Advance all stages together when the output register can take a result
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign factor  = pnu_pkg::ONE_Q16 -
                     ((damping_reg > pnu_pkg::ONE_Q16) ? pnu_pkg::ONE_Q16 : damping_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= pnu_pkg::MAX_SPEED_RST;
            damping_reg   <= pnu_pkg::DAMPING_RST;
            min_reg       <= {3{pnu_pkg::Q16_MIN}};
            max_reg       <= {3{pnu_pkg::Q16_MAX}};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pnu_pkg::REG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
                pnu_pkg::REG_DAMPING:   damping_reg   <= cfg_data[16:0];
                pnu_pkg::REG_MIN_X:     min_reg[0]    <= cfg_data;
                pnu_pkg::REG_MAX_X:     max_reg[0]    <= cfg_data;
                pnu_pkg::REG_MIN_Y:     min_reg[1]    <= cfg_data;
                pnu_pkg::REG_MAX_Y:     max_reg[1]    <= cfg_data;
                pnu_pkg::REG_MIN_Z:     min_reg[2]    <= cfg_data;
                pnu_pkg::REG_MAX_Z:     max_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Apply gravity to the y velocity unless the node is pinned
    always_comb begin
        gsum          = {s_vel_y[31], s_vel_y} + {s_gravity[31], s_gravity};
        a_next.pos[0] = s_pos_x;
        a_next.pos[1] = s_pos_y;
        a_next.pos[2] = s_pos_z;
        a_next.vel[0] = s_vel_x;
        a_next.vel[1] = s_node_locked ? s_vel_y : pnu_pkg::sat32({gsum[32], gsum});
        a_next.vel[2] = s_vel_z;
        a_next.lk     = {s_lock_z, s_lock_y, s_lock_x};
    end

    // Start the divider: partial remainder from the high product bits
    always_comb begin
        dv_in.nd   = sq_reg[pnu_pkg::SQRT_STEPS].nd;
        dv_in.neg  = sq_reg[pnu_pkg::SQRT_STEPS].neg;
        dv_in.over = sq_reg[pnu_pkg::SQRT_STEPS].over;
        dv_in.dvs  = sq_reg[pnu_pkg::SQRT_STEPS].res[31:0];
        for (int i = 0; i < 3; i++) begin
            dv_in.rem[i] = {2'b00, sq_reg[pnu_pkg::SQRT_STEPS].num[i][62:32]};
            dv_in.low[i] = sq_reg[pnu_pkg::SQRT_STEPS].num[i][31:0];
            dv_in.quo[i] = '0;
        end
    end

    // Pick the limited velocity, then move unlocked axes, then bounce; also restore the sign of the damped velocity
    always_comb begin
        f_next = dv_reg[pnu_pkg::DIV_STEPS-1].nd;
        for (int i = 0; i < 3; i++) begin
            if (dv_reg[pnu_pkg::DIV_STEPS-1].over) begin
                f_next.vel[i] = dv_reg[pnu_pkg::DIV_STEPS-1].neg[i] ?
                                (32'd0 - dv_reg[pnu_pkg::DIV_STEPS-1].quo[i]) :
                                dv_reg[pnu_pkg::DIV_STEPS-1].quo[i];
            end
        end
        g_next = f_reg;
        for (int i = 0; i < 3; i++) begin
            if (!f_reg.lk[i]) begin
                g_next.pos[i] = pnu_pkg::sat32({{2{f_reg.pos[i][31]}}, f_reg.pos[i]} +
                                               {{2{f_reg.vel[i][31]}}, f_reg.vel[i]});
            end
        end
        h_next = g_reg;
        for (int i = 0; i < 3; i++) begin
            if ($signed(g_reg.pos[i]) < $signed(min_reg[i])) begin
                h_next.pos[i] = pnu_pkg::sat32({min_reg[i][31], min_reg[i], 1'b0} -
                                               {{2{g_reg.pos[i][31]}}, g_reg.pos[i]});
                h_next.vel[i] = pnu_pkg::sat32(34'sd0 -
                                               {{2{g_reg.vel[i][31]}}, g_reg.vel[i]});
            end
        end
        i_next = h_reg;
        for (int i = 0; i < 3; i++) begin
            if ($signed(h_reg.pos[i]) > $signed(max_reg[i])) begin
                i_next.pos[i] = pnu_pkg::sat32({max_reg[i][31], max_reg[i], 1'b0} -
                                               {{2{h_reg.pos[i][31]}}, h_reg.pos[i]});
                i_next.vel[i] = pnu_pkg::sat32(34'sd0 -
                                               {{2{h_reg.vel[i][31]}}, h_reg.vel[i]});
            end
        end
        for (int i = 0; i < 3; i++) begin
            out_vel_next[i] = k_neg_reg[i] ? (32'd0 - k_prod_reg[i][47:16]) :
                                             k_prod_reg[i][47:16];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg   <= s_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            f_vld_reg   <= dv_vld_reg[pnu_pkg::DIV_STEPS-1];
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= i_vld_reg;
            k_vld_reg   <= j_vld_reg;
            out_vld_reg <= k_vld_reg;
        end
    end

    // Datapath stages outside the root and divider
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_next;
            b_reg <= a_reg;
            for (int i = 0; i < 3; i++) begin
                b_neg_reg[i] <= a_reg.vel[i][31];
                b_mag_reg[i] <= a_reg.vel[i][31] ? (~a_reg.vel[i] + 32'd1) : a_reg.vel[i];
            end
            c_reg      <= b_reg;
            c_neg_reg  <= b_neg_reg;
            for (int i = 0; i < 3; i++) begin
                c_sq_reg[i]  <= 64'(b_mag_reg[i]) * 64'(b_mag_reg[i]);
                c_num_reg[i] <= 63'(b_mag_reg[i]) * 63'(max_speed_reg);
            end
            c_lim2_reg <= 62'(max_speed_reg) * 62'(max_speed_reg);
            d_reg      <= c_reg;
            d_neg_reg  <= c_neg_reg;
            d_num_reg  <= c_num_reg;
            d_lim2_reg <= c_lim2_reg;
            d_mag2_reg <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            i_reg <= i_next;
            for (int i = 0; i < 3; i++) begin
                j_pos_reg[i] <= i_reg.pos[i];
                j_neg_reg[i] <= i_reg.vel[i][31];
                j_mag_reg[i] <= i_reg.vel[i][31] ? (~i_reg.vel[i] + 32'd1) : i_reg.vel[i];
            end
            k_pos_reg <= j_pos_reg;
            k_neg_reg <= j_neg_reg;
            for (int i = 0; i < 3; i++) begin
                k_prod_reg[i] <= 49'(j_mag_reg[i]) * 49'(factor);
            end
            out_pos_reg <= k_pos_reg;
            out_vel_reg <= out_vel_next;
        end
    end

    // Compare against the limit and load the root unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0].nd   <= d_reg;
            sq_reg[0].neg  <= d_neg_reg;
            sq_reg[0].num  <= d_num_reg;
            sq_reg[0].over <= d_mag2_reg > {2'b00, d_lim2_reg};
            sq_reg[0].n    <= d_mag2_reg;
            sq_reg[0].res  <= '0;
        end
    end

    // Square root: one result bit per stage
    for (genvar k = 0; k < pnu_pkg::SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[k+1] <= pnu_pkg::sqrt_step(sq_reg[k], BITV);
            end
        end
    end

    // Divider: one quotient bit per stage on all three lanes
    for (genvar j = 0; j < pnu_pkg::DIV_STEPS; j++) begin : g_div
        pnu_pkg::div_t src;
        logic          src_vld;
        if (j == 0) begin : g_first
            assign src     = dv_in;
            assign src_vld = sq_vld_reg[pnu_pkg::SQRT_STEPS];
        end else begin : g_next_stage
            assign src     = dv_reg[j-1];
            assign src_vld = dv_vld_reg[j-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[j] <= src_vld;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[j] <= pnu_pkg::div_step(src);
            end
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_new_pos_x = out_pos_reg[0];
    assign m_new_pos_y = out_pos_reg[1];
    assign m_new_pos_z = out_pos_reg[2];
    assign m_new_vel_x = out_vel_reg[0];
    assign m_new_vel_y = out_vel_reg[1];
    assign m_new_vel_z = out_vel_reg[2];

endmodule
